// ===== sv/keyed_access_stats_table_core_assert.svh =====
// assertion macros for the keyed access stats table core
// expects clk and rst_n in the scope where a macro is used
`ifndef KEYED_ACCESS_STATS_TABLE_CORE_ASSERT_SVH
`define KEYED_ACCESS_STATS_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define KAST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KAST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kast_pkg.sv =====
// package for the keyed access stats table core: sizes, status codes,
// word types and the home slot hash; no dependencies
package kast_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned DATA_W      = 64;

  localparam logic [DATA_W-1:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [DATA_W-1:0] HASH_PRIME = 64'h0000_0100_0000_01B3;

  localparam logic [1:0] STAT_IGNORED = 2'd0;
  localparam logic [1:0] STAT_HIT     = 2'd1;
  localparam logic [1:0] STAT_NEW     = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] object_id;
    logic [DATA_W-1:0] local_bytes;
    logic [DATA_W-1:0] remote_bytes;
    logic [DATA_W-1:0] miss_amount;
  } kast_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] access_count;
    logic [DATA_W-1:0] local_total;
    logic [DATA_W-1:0] remote_total;
    logic [DATA_W-1:0] miss_total;
    logic [DATA_W-1:0] probe_collisions;
  } kast_out_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] loc_sum;
    logic [DATA_W-1:0] rem_sum;
    logic [DATA_W-1:0] miss_sum;
  } kast_row_t;

  // low index bits of the product only depend on the low operand bits
  function automatic logic [IDX_W-1:0] home_slot(input logic [DATA_W-1:0] id);
    logic [2*IDX_W-1:0] prod;
    prod = {{IDX_W{1'b0}}, id[IDX_W-1:0] ^ HASH_BASIS[IDX_W-1:0]} *
           {{IDX_W{1'b0}}, HASH_PRIME[IDX_W-1:0]};
    return prod[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/keyed_access_stats_table_core.sv =====
// keyed access stats table core: linear probing table with a shared 64-bit adder
// depends on kast_pkg and keyed_access_stats_table_core_assert.svh
//
//   channel   ports                      handshake
//   input     start, busy, in_word       taken when start high and busy low
//   result    out_valid, out_word        one-cycle strobe, no back pressure
//
// after reset a clearing pass zeroes every one of the TABLE_DEPTH rows with busy high
// zero id: result in the cycle after the accept, busy stays low
// otherwise: each probe is a table read and a compare, then the adder steps (collisions, count,
//   local, remote, miss), then the write; the result is registered from the write, and a new accept can come with it
// full table: every row is probed, then only the collision add runs before the result
// one request is worked at a time, through the single table read port and the one shared adder
`include "keyed_access_stats_table_core_assert.svh"

module keyed_access_stats_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  kast_pkg::kast_in_t  in_word,
  output logic               out_valid,
  output kast_pkg::kast_out_t out_word
);
  import kast_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PROBE, ST_CHECK, ST_ADD, ST_WRITE
  } state_t;

  typedef enum logic [2:0] {
    OP_COLL, OP_COUNT, OP_LOCAL, OP_REMOTE, OP_MISS
  } add_op_t;

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH - 1);

  state_t            state_r, state_nxt;
  add_op_t           op_r, op_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  home_r, home_nxt;
  logic [IDX_W-1:0]  steps_r, steps_nxt;
  logic [1:0]        status_r, status_nxt;
  kast_in_t          in_r, in_nxt;
  logic [DATA_W-1:0] coll_r, coll_nxt;
  logic [DATA_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0] loc_r, loc_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] mis_r, mis_nxt;
  logic              out_valid_r, out_valid_nxt;
  kast_out_t         out_word_r, out_word_nxt;

  logic [IDX_W-1:0]  pos_inc;
  logic [DATA_W-1:0] add_a, add_b, add_sum;

  kast_row_t         mem [TABLE_DEPTH];
  kast_row_t         rd_row_r;
  kast_row_t         mem_wdata;
  logic              mem_we;
  logic              mem_re;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign pos_inc   = pos_r + IDX_W'(1);

  // shared adder
  always_comb begin
    case (op_r)
      OP_COLL: begin
        add_a = coll_r;
        add_b = DATA_W'(steps_r);
      end
      OP_COUNT: begin
        add_a = cnt_r;
        add_b = DATA_W'(1);
      end
      OP_LOCAL: begin
        add_a = loc_r;
        add_b = in_r.local_bytes;
      end
      OP_REMOTE: begin
        add_a = rem_r;
        add_b = in_r.remote_bytes;
      end
      OP_MISS: begin
        add_a = mis_r;
        add_b = in_r.miss_amount;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  // table memory
  assign mem_re = (state_r == ST_PROBE);
  assign mem_we = (state_r == ST_CLEAR) || (state_r == ST_WRITE);

  always_comb begin
    mem_wdata = '0;
    if (state_r == ST_WRITE) begin
      mem_wdata.valid    = 1'b1;
      mem_wdata.key      = in_r.object_id;
      mem_wdata.count    = cnt_r;
      mem_wdata.loc_sum  = loc_r;
      mem_wdata.rem_sum  = rem_r;
      mem_wdata.miss_sum = mis_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= mem[pos_r];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    home_nxt      = home_r;
    steps_nxt     = steps_r;
    status_nxt    = status_r;
    in_nxt        = in_r;
    coll_nxt      = coll_r;
    cnt_nxt       = cnt_r;
    loc_nxt       = loc_r;
    rem_nxt       = rem_r;
    mis_nxt       = mis_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      ST_CLEAR: begin
        pos_nxt = pos_inc;
        if (pos_r == IDX_MAX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          in_nxt = in_word;
          if (in_word.object_id == '0) begin
            out_valid_nxt                 = 1'b1;
            out_word_nxt                  = '0;
            out_word_nxt.status           = STAT_IGNORED;
            out_word_nxt.probe_collisions = coll_r;
          end else begin
            home_nxt  = home_slot(in_word.object_id);
            pos_nxt   = home_nxt;
            steps_nxt = '0;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        op_nxt = OP_COLL;
        if (!rd_row_r.valid) begin
          status_nxt = STAT_NEW;
          cnt_nxt    = '0;
          loc_nxt    = '0;
          rem_nxt    = '0;
          mis_nxt    = '0;
          state_nxt  = ST_ADD;
        end else if (rd_row_r.key == in_r.object_id) begin
          status_nxt = STAT_HIT;
          cnt_nxt    = rd_row_r.count;
          loc_nxt    = rd_row_r.loc_sum;
          rem_nxt    = rd_row_r.rem_sum;
          mis_nxt    = rd_row_r.miss_sum;
          state_nxt  = ST_ADD;
        end else if (pos_inc == home_r) begin
          status_nxt = STAT_FULL;
          state_nxt  = ST_ADD;
        end else begin
          pos_nxt   = pos_inc;
          steps_nxt = steps_r + IDX_W'(1);
          state_nxt = ST_PROBE;
        end
      end
      ST_ADD: begin
        case (op_r)
          OP_COLL:   coll_nxt = add_sum;
          OP_COUNT:  cnt_nxt  = add_sum;
          OP_LOCAL:  loc_nxt  = add_sum;
          OP_REMOTE: rem_nxt  = add_sum;
          OP_MISS:   mis_nxt  = add_sum;
          default:   coll_nxt = coll_r;
        endcase
        if ((op_r == OP_COLL) && (status_r == STAT_FULL)) begin
          out_valid_nxt                 = 1'b1;
          out_word_nxt                  = '0;
          out_word_nxt.status           = STAT_FULL;
          out_word_nxt.probe_collisions = add_sum;
          state_nxt                     = ST_IDLE;
        end else if (op_r == OP_MISS) begin
          state_nxt = ST_WRITE;
        end else begin
          op_nxt = add_op_t'(op_r + 3'd1);
        end
      end
      ST_WRITE: begin
        out_valid_nxt                 = 1'b1;
        out_word_nxt.status           = status_r;
        out_word_nxt.slot_index       = SLOT_W'(pos_r);
        out_word_nxt.access_count     = cnt_r;
        out_word_nxt.local_total      = loc_r;
        out_word_nxt.remote_total     = rem_r;
        out_word_nxt.miss_total       = mis_r;
        out_word_nxt.probe_collisions = coll_r;
        state_nxt                     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      op_r        <= OP_COLL;
      pos_r       <= '0;
      home_r      <= '0;
      steps_r     <= '0;
      status_r    <= STAT_IGNORED;
      coll_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      pos_r       <= pos_nxt;
      home_r      <= home_nxt;
      steps_r     <= steps_nxt;
      status_r    <= status_nxt;
      coll_r      <= coll_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r       <= in_nxt;
    cnt_r      <= cnt_nxt;
    loc_r      <= loc_nxt;
    rem_r      <= rem_nxt;
    mis_r      <= mis_nxt;
    out_word_r <= out_word_nxt;
  end

  // checks
  `KAST_ASSERT_NOW(a_probe_offset, state_r == ST_CHECK, pos_r == IDX_W'(home_r + steps_r), "probe position off home plus steps")
  `KAST_ASSERT_NOW(a_result_idle, out_valid_r, !busy, "result while busy")
  `KAST_ASSERT_NEXT(a_busy_after_key, start && !busy && (in_word.object_id != '0), busy, "no work after keyed accept")
  `KAST_ASSERT_NOW(a_drop_zeroed, out_valid_r && ((out_word_r.status == STAT_FULL) || (out_word_r.status == STAT_IGNORED)), (out_word_r.slot_index == '0) && (out_word_r.access_count == '0) && (out_word_r.miss_total == '0), "dropped word not zeroed")

endmodule
